/* hdl/q8sf_pkg.sv */
// shared constants and types of the quad8 shape function evaluator
`default_nettype none

package q8sf_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COORD_W   = 16;
    localparam int OUT_W     = 16;
    localparam int NODE_W    = 3;
    localparam int NUM_NODES = 8;

    // signed width of the constant one (2^FRAC_BITS)
    localparam int ONE_W   = FRAC_BITS + 2;
    // operands are sums of up to three coordinate-sized values
    localparam int OP_W    = ((COORD_W > ONE_W) ? COORD_W : ONE_W) + 3;
    localparam int PROD2_W = 2 * OP_W;
    localparam int PROD3_W = 3 * OP_W;
    localparam int SUM_W   = PROD3_W + 1;
    localparam int SHIFT_W = $clog2(2 * FRAC_BITS + 3);

    localparam int QUEUE_DEPTH = 2;

    localparam int IN_DATA_W  = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_FLD_W  = NODE_W + 3 * OUT_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // node numbering: corners are even, midsides odd
    localparam logic [NODE_W-1:0] NODE_CORNER_SW = NODE_W'(0);
    localparam logic [NODE_W-1:0] NODE_MID_S     = NODE_W'(1);
    localparam logic [NODE_W-1:0] NODE_CORNER_SE = NODE_W'(2);
    localparam logic [NODE_W-1:0] NODE_MID_E     = NODE_W'(3);
    localparam logic [NODE_W-1:0] NODE_CORNER_NE = NODE_W'(4);
    localparam logic [NODE_W-1:0] NODE_MID_N     = NODE_W'(5);
    localparam logic [NODE_W-1:0] NODE_CORNER_NW = NODE_W'(6);
    localparam logic [NODE_W-1:0] NODE_MID_W     = NODE_W'(7);
    localparam logic [NODE_W-1:0] NODE_LAST      = NODE_W'(NUM_NODES - 1);

    typedef logic signed [OP_W-1:0] op_t;

    localparam op_t ONE_FX = op_t'(64'sd1 <<< FRAC_BITS);

    // coordinates with the offsets used by every node already formed
    typedef struct packed {
        op_t x;
        op_t y;
        op_t xp;   // one + x
        op_t xm;   // x - one
        op_t yp;   // one + y
        op_t ym;   // y - one
    } q8sf_coord_t;

    typedef struct packed {
        logic        valid;
        q8sf_coord_t coord;
    } q8sf_head_t;

endpackage

`default_nettype wire

/* hdl/q8sf_front.sv */
// front end: takes coordinate requests, forms offsets, queues them
`default_nettype none

module q8sf_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [q8sf_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // xi_coord, eta_coord
    input  wire logic                             pop,
    output q8sf_pkg::q8sf_head_t                  head
);

    localparam int PTR_W = (q8sf_pkg::QUEUE_DEPTH > 1) ? $clog2(q8sf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(q8sf_pkg::QUEUE_DEPTH + 1);

    q8sf_pkg::q8sf_coord_t entry_reg [q8sf_pkg::QUEUE_DEPTH];
    q8sf_pkg::q8sf_coord_t in_coord;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             do_pop;

    always_comb
    begin
        in_coord.x  = q8sf_pkg::op_t'($signed(s_axis_tdata[q8sf_pkg::COORD_W-1:0]));
        in_coord.y  = q8sf_pkg::op_t'($signed(
                          s_axis_tdata[2*q8sf_pkg::COORD_W-1:q8sf_pkg::COORD_W]));
        in_coord.xp = q8sf_pkg::ONE_FX + in_coord.x;
        in_coord.xm = in_coord.x - q8sf_pkg::ONE_FX;
        in_coord.yp = q8sf_pkg::ONE_FX + in_coord.y;
        in_coord.ym = in_coord.y - q8sf_pkg::ONE_FX;
    end

    assign s_axis_tready = (count_reg != CNT_W'(q8sf_pkg::QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign do_pop        = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(q8sf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(q8sf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_coord;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.coord = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

/* hdl/q8sf_back.sv */
// back end: node sequencer and pipelined shape function evaluation
`default_nettype none

module q8sf_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire q8sf_pkg::q8sf_head_t             head,
    output logic                                  pop,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [q8sf_pkg::OUT_DATA_W-1:0]       m_axis_tdata,   // node_index, shape_value,
                                                                  // deriv_xi, deriv_eta
    output logic                                  m_axis_tlast    // last_node
);

    localparam int NW = q8sf_pkg::NODE_W;
    localparam int SW = q8sf_pkg::SHIFT_W;
    localparam int P2 = q8sf_pkg::PROD2_W;
    localparam int P3 = q8sf_pkg::PROD3_W;
    localparam int SM = q8sf_pkg::SUM_W;
    localparam int OW = q8sf_pkg::OUT_W;

    localparam logic [SW-1:0] K_F0 = SW'(q8sf_pkg::FRAC_BITS);
    localparam logic [SW-1:0] K_F1 = SW'(q8sf_pkg::FRAC_BITS + 1);
    localparam logic [SW-1:0] K_F2 = SW'(q8sf_pkg::FRAC_BITS + 2);
    localparam logic [SW-1:0] K_MID = SW'(2 * q8sf_pkg::FRAC_BITS + 1);
    localparam logic [SW-1:0] K_CRN = SW'(2 * q8sf_pkg::FRAC_BITS + 2);

    localparam logic [SM-1:0] SAT_POS = SM'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic [SM-1:0] SAT_NEG = SM'(64'd1 << (OW - 1));
    localparam int PAD_W = q8sf_pkg::OUT_DATA_W - q8sf_pkg::OUT_FLD_W;

    // magnitude plus half an lsb of the result, ties go away from zero
    function automatic logic [SM-1:0] round_add(input logic signed [P3-1:0] p,
                                                input logic [SW-1:0] k);
        logic [SM-1:0] half;
        logic [SM-1:0] base;
        half = SM'(1) << (k - SW'(1));
        if (p[P3-1])
        begin
            base = {1'b0, ~p};
            return base + half + SM'(1);
        end
        base = {1'b0, p};
        return base + half;
    endfunction

    function automatic logic [OW-1:0] shift_sat(input logic [SM-1:0] sum,
                                                input logic neg,
                                                input logic [SW-1:0] k);
        logic [SM-1:0] q;
        logic [SM-1:0] qn;
        q  = sum >> k;
        qn = ~q + SM'(1);
        if (neg)
        begin
            return (q > SAT_NEG) ? SAT_NEG[OW-1:0] : qn[OW-1:0];
        end
        return (q > SAT_POS) ? SAT_POS[OW-1:0] : q[OW-1:0];
    endfunction

    logic adv;
    logic issue;

    logic [NW-1:0] node_reg, node_next;

    // operand selection for the node about to issue
    q8sf_pkg::op_t   op_a, op_b, op_c, dx_a, dx_b, dy_a, dy_b;
    logic [SW-1:0]   k_v, k_dx, k_dy;
    q8sf_pkg::op_t   x, y, xp, xm, yp, ym;

    // stage 1: operands
    logic            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [NW-1:0]   n1_reg, n2_reg, n3_reg, n4_reg;
    logic            l1_reg, l2_reg, l3_reg, l4_reg;
    q8sf_pkg::op_t   a1_reg, b1_reg, c1_reg, dxa1_reg, dxb1_reg, dya1_reg, dyb1_reg;
    logic [SW-1:0]   kv1_reg, kdx1_reg, kdy1_reg;
    // stage 2: first products
    logic signed [P2-1:0] pv2_reg, pdx2_reg, pdy2_reg;
    q8sf_pkg::op_t        c2_reg;
    logic [SW-1:0]        kv2_reg, kdx2_reg, kdy2_reg;
    // stage 3: full products
    logic signed [P3-1:0] pv3_reg, pdx3_reg, pdy3_reg;
    logic [SW-1:0]        kv3_reg, kdx3_reg, kdy3_reg;
    // stage 4: rounded magnitudes
    logic [SM-1:0]        sv4_reg, sdx4_reg, sdy4_reg;
    logic                 nv4_reg, ndx4_reg, ndy4_reg;
    logic [SW-1:0]        kv4_reg, kdx4_reg, kdy4_reg;
    // stage 5: output register
    logic [NW-1:0]        out_node_reg;
    logic                 out_last_reg;
    logic [OW-1:0]        out_val_reg, out_dx_reg, out_dy_reg;

    assign adv   = !v5_reg || m_axis_tready;
    assign issue = adv && head.valid;
    assign pop   = issue && (node_reg == q8sf_pkg::NODE_LAST);

    assign node_next = issue ? node_reg + 1'b1 : node_reg;

    assign x  = head.coord.x;
    assign y  = head.coord.y;
    assign xp = head.coord.xp;
    assign xm = head.coord.xm;
    assign yp = head.coord.yp;
    assign ym = head.coord.ym;

    always_comb
    begin
        op_a = xm;
        op_b = -ym;
        op_c = xp + y;
        k_v  = K_CRN;
        dx_a = -ym;
        dx_b = x + x + y;
        k_dx = K_F2;
        dy_a = -xm;
        dy_b = x + y + y;
        k_dy = K_F2;
        case (node_reg)
            q8sf_pkg::NODE_CORNER_SW:
            begin
                op_a = xm;     op_b = -ym;       op_c = xp + y;   k_v  = K_CRN;
                dx_a = -ym;    dx_b = x + x + y;                  k_dx = K_F2;
                dy_a = -xm;    dy_b = x + y + y;                  k_dy = K_F2;
            end
            q8sf_pkg::NODE_MID_S:
            begin
                op_a = -xm;    op_b = xp;        op_c = -ym;      k_v  = K_MID;
                dx_a = x;      dx_b = ym;                         k_dx = K_F0;
                dy_a = xp;     dy_b = xm;                         k_dy = K_F1;
            end
            q8sf_pkg::NODE_CORNER_SE:
            begin
                op_a = -xp;    op_b = -ym;       op_c = yp - x;   k_v  = K_CRN;
                dx_a = ym;     dx_b = y - x - x;                  k_dx = K_F2;
                dy_a = xp;     dy_b = y + y - x;                  k_dy = K_F2;
            end
            q8sf_pkg::NODE_MID_E:
            begin
                op_a = xp;     op_b = yp;        op_c = -ym;      k_v  = K_MID;
                dx_a = yp;     dx_b = -ym;                        k_dx = K_F1;
                dy_a = -y;     dy_b = xp;                         k_dy = K_F0;
            end
            q8sf_pkg::NODE_CORNER_NE:
            begin
                op_a = -xp;    op_b = yp;        op_c = -xm - y;  k_v  = K_CRN;
                dx_a = yp;     dx_b = x + x + y;                  k_dx = K_F2;
                dy_a = xp;     dy_b = x + y + y;                  k_dy = K_F2;
            end
            q8sf_pkg::NODE_MID_N:
            begin
                op_a = -xm;    op_b = xp;        op_c = yp;       k_v  = K_MID;
                dx_a = -x;     dx_b = yp;                         k_dx = K_F0;
                dy_a = xp;     dy_b = -xm;                        k_dy = K_F1;
            end
            q8sf_pkg::NODE_CORNER_NW:
            begin
                op_a = xm;     op_b = yp;        op_c = xp - y;   k_v  = K_CRN;
                dx_a = yp;     dx_b = x + x - y;                  k_dx = K_F2;
                dy_a = -xm;    dy_b = y + y - x;                  k_dy = K_F2;
            end
            q8sf_pkg::NODE_MID_W:
            begin
                op_a = -xm;    op_b = yp;        op_c = -ym;      k_v  = K_MID;
                dx_a = yp;     dx_b = ym;                         k_dx = K_F1;
                dy_a = y;      dy_b = xm;                         k_dy = K_F0;
            end
            default:
            begin
                op_a = xm;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
        end
        else
        begin
            node_reg <= node_next;
            if (adv)
            begin
                v1_reg <= head.valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg   <= node_reg;
            l1_reg   <= (node_reg == q8sf_pkg::NODE_LAST);
            a1_reg   <= op_a;
            b1_reg   <= op_b;
            c1_reg   <= op_c;
            dxa1_reg <= dx_a;
            dxb1_reg <= dx_b;
            dya1_reg <= dy_a;
            dyb1_reg <= dy_b;
            kv1_reg  <= k_v;
            kdx1_reg <= k_dx;
            kdy1_reg <= k_dy;

            n2_reg   <= n1_reg;
            l2_reg   <= l1_reg;
            pv2_reg  <= a1_reg * b1_reg;
            pdx2_reg <= dxa1_reg * dxb1_reg;
            pdy2_reg <= dya1_reg * dyb1_reg;
            c2_reg   <= c1_reg;
            kv2_reg  <= kv1_reg;
            kdx2_reg <= kdx1_reg;
            kdy2_reg <= kdy1_reg;

            n3_reg   <= n2_reg;
            l3_reg   <= l2_reg;
            pv3_reg  <= pv2_reg * c2_reg;
            pdx3_reg <= P3'(pdx2_reg);
            pdy3_reg <= P3'(pdy2_reg);
            kv3_reg  <= kv2_reg;
            kdx3_reg <= kdx2_reg;
            kdy3_reg <= kdy2_reg;

            n4_reg   <= n3_reg;
            l4_reg   <= l3_reg;
            sv4_reg  <= round_add(pv3_reg, kv3_reg);
            sdx4_reg <= round_add(pdx3_reg, kdx3_reg);
            sdy4_reg <= round_add(pdy3_reg, kdy3_reg);
            nv4_reg  <= pv3_reg[P3-1];
            ndx4_reg <= pdx3_reg[P3-1];
            ndy4_reg <= pdy3_reg[P3-1];
            kv4_reg  <= kv3_reg;
            kdx4_reg <= kdx3_reg;
            kdy4_reg <= kdy3_reg;

            out_node_reg <= n4_reg;
            out_last_reg <= l4_reg;
            out_val_reg  <= shift_sat(sv4_reg, nv4_reg, kv4_reg);
            out_dx_reg   <= shift_sat(sdx4_reg, ndx4_reg, kdx4_reg);
            out_dy_reg   <= shift_sat(sdy4_reg, ndy4_reg, kdy4_reg);
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_dy_reg, out_dx_reg, out_val_reg, out_node_reg};

endmodule

`default_nettype wire

/* hdl/quad8_shape_function_eval.sv */
// top level: 8-node serendipity quadrilateral shape function evaluator
// throughput: one node result per cycle while the output is not stalled and a request is queued;
//   so the node sequencer issues one node a cycle into a single 5-stage evaluation pipeline
// a 2-entry queue holds the request being evaluated and one further request
// reset clears the queue pointers and count, node counter and pipeline valid bits
`default_nettype none

module quad8_shape_function_eval (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [q8sf_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // xi_coord, eta_coord
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [q8sf_pkg::OUT_DATA_W-1:0]       m_axis_tdata,   // node_index, shape_value,
                                                                  // deriv_xi, deriv_eta
    output logic                                  m_axis_tlast    // last_node
);

    q8sf_pkg::q8sf_head_t head;
    logic                 pop;

    q8sf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .pop           (pop),
        .head          (head)
    );

    q8sf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
